FILE: src/pwtm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwtm_pkg
// Shared types and constants for the percent wildcard text matcher.
// ----------------------------------------------------------------------------
package pwtm_pkg;

  localparam int unsigned PATTERN_MAX_DEF = 64;
  localparam logic [7:0]  WILDCARD        = 8'h25;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_TEXT   = 2'd2,
    ACT_END    = 2'd3
  } action_t;

  typedef struct packed {
    logic clear;
    logic append;
    logic text;
    logic finish;
  } cmd_t;

endpackage
`default_nettype wire

FILE: src/percent_wildcard_text_matcher_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// percent_wildcard_text_matcher_unit
// Streams text bytes against a stored pattern where '%' matches any run.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall, action, byte_value): clear the
//   pattern, append a pattern byte, feed a text byte, or end the text.
//   Result channel (res_valid / res_stall, matched, pattern_overflow): one
//   result per end of text, none for the other actions.
//   Path: a request is held in an input register, and an end of text then
//   loads its result into the result register, which raises res_valid.
//   Throughput: one request per cycle while req_stall is low, as the active
//   position vector is updated for all pattern positions in parallel.
//   Reset: pattern empty, overflow flag clear, only position zero active;
//   pattern bytes are written before use and carry no reset.
//   Stall: while res_stall holds a result, text and pattern requests still
//   go through; an end of text waits in the input register and req_stall
//   rises until the result register is free.
// ----------------------------------------------------------------------------
module percent_wildcard_text_matcher_unit
  import pwtm_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        req_valid,
  output logic       req_stall,
  input  wire  [1:0] action,
  input  wire  [7:0] byte_value,
  output logic       res_valid,
  input  wire        res_stall,
  output logic       matched,
  output logic       pattern_overflow
);

  localparam int unsigned LENW = $clog2(PATTERN_MAX + 1);

  logic                   hold_valid;
  action_t                hold_action;
  logic [7:0]             hold_byte;
  logic                   advance;
  cmd_t                   cmd;
  logic [PATTERN_MAX-1:0] wild_mask;
  logic [PATTERN_MAX-1:0] hit_mask;
  logic [LENW-1:0]        len;
  logic                   overflow;
  logic                   match_now;

  assign advance   = hold_valid && ((hold_action != ACT_END) || !res_valid || !res_stall);
  assign req_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      hold_action <= action_t'(action);
      hold_byte   <= byte_value;
    end
  end

  always_comb begin
    cmd = '0;
    if (advance) begin
      case (hold_action)
        ACT_CLEAR:  cmd.clear  = 1'b1;
        ACT_APPEND: cmd.append = 1'b1;
        ACT_TEXT:   cmd.text   = 1'b1;
        ACT_END:    cmd.finish = 1'b1;
        default:    cmd        = '0;
      endcase
    end
  end

  pwtm_pattern_store #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .byte_value (hold_byte),
    .wild_mask  (wild_mask),
    .hit_mask   (hit_mask),
    .len        (len),
    .overflow   (overflow)
  );

  pwtm_position_engine #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .wild_mask (wild_mask),
    .hit_mask  (hit_mask),
    .len       (len),
    .matched   (match_now)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.finish) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      matched          <= match_now;
      pattern_overflow <= overflow;
    end
  end

`ifndef SYNTH
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    overflow |-> (len == LENW'(PATTERN_MAX)))
    else $error("overflow flag set with pattern not full");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> ((len == '0) && !overflow))
    else $error("pattern not emptied after clear");

  a_stall_needs_hold: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (hold_valid && (hold_action == ACT_END) && res_valid))
    else $error("request stalled without a waiting end of text");

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> res_valid)
    else $error("end of text gave no result");
`endif

endmodule
`default_nettype wire

FILE: src/pwtm_pattern_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwtm_pattern_store
// Pattern byte cells, length and overflow flag; per-position wildcard and
// text byte hit vectors for the position engine.
// ----------------------------------------------------------------------------
module pwtm_pattern_store
  import pwtm_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF,
  localparam int unsigned LENW = $clog2(PATTERN_MAX + 1)
) (
  input  wire                    clk,
  input  wire                    rst,
  input  cmd_t                   cmd,
  input  wire  [7:0]             byte_value,
  output logic [PATTERN_MAX-1:0] wild_mask,
  output logic [PATTERN_MAX-1:0] hit_mask,
  output logic [LENW-1:0]        len,
  output logic                   overflow
);

  logic [7:0] pat [PATTERN_MAX];
  logic       full;

  assign full = (len == LENW'(PATTERN_MAX));

  always_ff @(posedge clk) begin
    if (rst) begin
      len      <= '0;
      overflow <= 1'b0;
    end else if (cmd.clear) begin
      len      <= '0;
      overflow <= 1'b0;
    end else if (cmd.append) begin
      if (full) begin
        overflow <= 1'b1;
      end else begin
        len <= len + LENW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (cmd.append && (len == LENW'(i))) begin
        pat[i] <= byte_value;
      end
    end
  end

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic used;
    logic wild;

    assign used         = (LENW'(i) < len);
    assign wild         = (pat[i] == WILDCARD);
    assign wild_mask[i] = used && wild;
    assign hit_mask[i]  = used && !wild && (pat[i] == byte_value);
  end

endmodule
`default_nettype wire

FILE: src/pwtm_position_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwtm_position_engine
// Active position set: wildcard closure by a parallel prefix network, one
// advance per text byte, match check at end of text.
// ----------------------------------------------------------------------------
module pwtm_position_engine
  import pwtm_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF,
  localparam int unsigned LENW   = $clog2(PATTERN_MAX + 1),
  localparam int unsigned LEVELS = $clog2(PATTERN_MAX + 1)
) (
  input  wire                    clk,
  input  wire                    rst,
  input  cmd_t                   cmd,
  input  wire  [PATTERN_MAX-1:0] wild_mask,
  input  wire  [PATTERN_MAX-1:0] hit_mask,
  input  wire  [LENW-1:0]        len,
  output logic                   matched
);

  logic [PATTERN_MAX:0] active;
  logic [PATTERN_MAX:0] active_next;
  logic [PATTERN_MAX:0] closed;
  logic [PATTERN_MAX:0] gen_lv  [LEVELS+1];
  logic [PATTERN_MAX:0] prop_lv [LEVELS+1];

  assign gen_lv[0]  = active;
  assign prop_lv[0] = {wild_mask, 1'b0};

  for (genvar k = 0; k < LEVELS; k++) begin : g_level
    for (genvar j = 0; j <= PATTERN_MAX; j++) begin : g_bit
      if (j >= (1 << k)) begin : g_join
        assign gen_lv[k+1][j]  = gen_lv[k][j] | (prop_lv[k][j] & gen_lv[k][j-(1<<k)]);
        assign prop_lv[k+1][j] = prop_lv[k][j] & prop_lv[k][j-(1<<k)];
      end else begin : g_pass
        assign gen_lv[k+1][j]  = gen_lv[k][j];
        assign prop_lv[k+1][j] = prop_lv[k][j];
      end
    end
  end

  assign closed  = gen_lv[LEVELS];
  assign matched = closed[len];

  always_comb begin
    active_next = active;
    if (cmd.clear || cmd.finish) begin
      active_next = (PATTERN_MAX+1)'(1);
    end else if (cmd.text) begin
      active_next = (closed & {1'b0, wild_mask})
                  | {closed[PATTERN_MAX-1:0] & hit_mask, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= (PATTERN_MAX+1)'(1);
    end else begin
      active <= active_next;
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/tb_percent_wildcard_text_matcher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_percent_wildcard_text_matcher_unit
// Drives pattern and text requests into the wildcard matcher and checks every
// end-of-text result against a cycle-free model of the active position set.
// Directed cases cover empty text, wildcard closure, literal '%' text, clears
// and appends in the middle of a text; random sets build a pattern, derive
// matching and near-matching texts from it, overflow it now and then, and mix
// in noise. Both channels idle at random, and the result side holds off for
// long stretches so that the input backs up.
// ----------------------------------------------------------------------------
module tb_percent_wildcard_text_matcher_unit;
  import pwtm_pkg::*;

  localparam int CAP          = PATTERN_MAX_DEF;
  localparam int QUIET_LIMIT  = 1000;
  localparam int HOLD_LEN     = 80;
  localparam int HOLD_FIRST   = 150;
  localparam int HOLD_SECOND  = 900;
  localparam int CALM_START   = 400;
  localparam int CALM_STOP    = 700;
  localparam int RANDOM_ITEMS = 500;

  typedef struct {
    action_t    act;
    logic [7:0] val;
  } request_t;

  typedef struct {
    logic matched;
    logic overflow;
  } result_t;

  logic       clk;
  logic       rst        = 1'b1;
  logic       req_valid  = 1'b0;
  logic       req_stall;
  action_t    action     = ACT_CLEAR;
  logic [7:0] byte_value = 8'h00;
  logic       res_valid;
  logic       res_stall  = 1'b0;
  logic       matched;
  logic       pattern_overflow;

  request_t pending_requests[$];
  result_t  awaited_results[$];

  logic [7:0]   pat_mem [CAP];
  int           pat_len;
  logic [CAP:0] live_pos;
  logic         ovf_flag;

  int  cyc          = 0;
  int  quiet_cycles = 0;
  int  errors       = 0;
  int  hold_left    = 0;
  int  gen_total    = 0;
  logic calm;

  assign calm = (cyc >= CALM_START) && (cyc < CALM_STOP);

  percent_wildcard_text_matcher_unit dut (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .action           (action),
    .byte_value       (byte_value),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .matched          (matched),
    .pattern_overflow (pattern_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Matching model
  // --------------------------------------------------------------------------
  function automatic void restart_live();
    live_pos    = '0;
    live_pos[0] = 1'b1;
  endfunction

  function automatic void close_wildcards();
    for (int i = 0; i < pat_len; i++) begin
      if (live_pos[i] && pat_mem[i] == WILDCARD) live_pos[i+1] = 1'b1;
    end
  endfunction

  function automatic void match_step(action_t act, logic [7:0] b);
    logic [CAP:0] nxt;
    result_t      res;
    case (act)
      ACT_CLEAR: begin
        pat_len  = 0;
        ovf_flag = 1'b0;
        restart_live();
      end
      ACT_APPEND: begin
        if (pat_len < CAP) begin
          pat_mem[pat_len] = b;
          pat_len++;
        end else begin
          ovf_flag = 1'b1;
        end
      end
      ACT_TEXT: begin
        close_wildcards();
        nxt = '0;
        for (int i = 0; i < pat_len; i++) begin
          if (live_pos[i]) begin
            if (pat_mem[i] == WILDCARD) nxt[i] = 1'b1;
            else if (pat_mem[i] == b) nxt[i+1] = 1'b1;
          end
        end
        live_pos = nxt;
      end
      ACT_END: begin
        close_wildcards();
        res.matched  = live_pos[pat_len];
        res.overflow = ovf_flag;
        awaited_results = {awaited_results, res};
        restart_live();
      end
      default: begin
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic void push_request(action_t act, logic [7:0] val);
    request_t r;
    r.act = act;
    r.val = val;
    pending_requests = {pending_requests, r};
    gen_total++;
  endfunction

  function automatic logic [7:0] pick_pattern_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return WILDCARD;
    if (r < 6) return 8'h61;
    if (r < 8) return 8'h62;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 8'h61;
    if (r < 5) return 8'h62;
    if (r < 6) return WILDCARD;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void add_match_set();
    logic [7:0] pat[$];
    int         plen;
    int         ntexts;
    push_request(ACT_CLEAR, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 24) == 0) begin
      plen   = $urandom_range(CAP - 4, CAP + 6);
      ntexts = 1;
    end else begin
      plen   = $urandom_range(0, 8);
      ntexts = $urandom_range(1, 3);
    end
    for (int k = 0; k < plen; k++) begin
      pat = {pat, pick_pattern_byte()};
      push_request(ACT_APPEND, pat[k]);
    end
    repeat (ntexts) begin
      foreach (pat[k]) begin
        if (pat[k] == WILDCARD) begin
          repeat ($urandom_range(0, 3)) push_request(ACT_TEXT, pick_text_byte());
        end else if ($urandom_range(0, 9) == 0) begin
          push_request(ACT_TEXT, 8'($urandom_range(0, 255)));
        end else if ($urandom_range(0, 19) != 0) begin
          push_request(ACT_TEXT, pat[k]);
        end
        if ($urandom_range(0, 39) == 0) push_request(ACT_APPEND, pick_pattern_byte());
      end
      push_request(ACT_END, 8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void add_noise();
    repeat ($urandom_range(1, 4)) begin
      push_request(action_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end
  endfunction

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    request_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) match_step(action, byte_value);
      if (!req_valid || !req_stall) begin
        if (pending_requests.size() != 0 && (calm || $urandom_range(0, 99) >= 36)) begin
          nxt = pending_requests.pop_front();
          action     <= nxt.act;
          byte_value <= nxt.val;
          req_valid  <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (awaited_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: matched=%0b overflow=%0b",
                     matched, pattern_overflow);
        end else begin
          want = awaited_results.pop_front();
          if (matched !== want.matched || pattern_overflow !== want.overflow) begin
            errors++;
            if (errors <= 10)
              $display("result mismatch: expected %0b/%0b, got %0b/%0b",
                       want.matched, want.overflow, matched, pattern_overflow);
          end
        end
      end
      // hold off long enough for the input side to back up
      if (cyc == HOLD_FIRST || cyc == HOLD_SECOND) hold_left = HOLD_LEN;
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= !calm && ($urandom_range(0, 99) < 36);
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if ((req_valid && !req_stall) || (res_valid && !res_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("** percent_wildcard_text_matcher_unit: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : run_sequence
    int directed_total;
    pat_len  = 0;
    ovf_flag = 1'b0;
    restart_live();

    push_request(ACT_END, 8'h00);
    push_request(ACT_APPEND, WILDCARD);
    push_request(ACT_END, 8'hFF);
    push_request(ACT_TEXT, 8'h00);
    push_request(ACT_TEXT, 8'hFF);
    push_request(ACT_END, 8'h5A);
    push_request(ACT_CLEAR, 8'hFF);
    push_request(ACT_APPEND, 8'h00);
    push_request(ACT_APPEND, 8'hFF);
    push_request(ACT_TEXT, 8'h00);
    push_request(ACT_TEXT, 8'hFF);
    push_request(ACT_END, 8'h00);
    push_request(ACT_CLEAR, 8'h00);
    push_request(ACT_APPEND, 8'h61);
    push_request(ACT_TEXT, WILDCARD);
    push_request(ACT_END, 8'h00);
    // append in the middle of a text
    push_request(ACT_TEXT, 8'h61);
    push_request(ACT_APPEND, WILDCARD);
    push_request(ACT_TEXT, 8'h7A);
    push_request(ACT_END, 8'h00);
    // clear in the middle of a text
    push_request(ACT_TEXT, 8'h71);
    push_request(ACT_CLEAR, 8'hA5);
    push_request(ACT_END, 8'hFF);
    directed_total = gen_total;

    while (gen_total < directed_total + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 8) add_match_set();
      else add_noise();
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || req_valid) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (errors == 0 && awaited_results.size() == 0)
      $display("** percent_wildcard_text_matcher_unit: PASSED **");
    else
      $display("** percent_wildcard_text_matcher_unit: FAILED **");
    $finish;
  end

endmodule
